/* hw/rtl/sbeu_pkg.sv */
// ----------------------------------------------------------------------------
// sbeu_pkg
// Shared opcodes, error codes and request/result types of the bytecode unit.
// ----------------------------------------------------------------------------
package sbeu_pkg;

  typedef enum logic [4:0] {
    OP_NOP   = 5'd0,  OP_PUSHI = 5'd1,  OP_PUSHB = 5'd2,  OP_POP   = 5'd3,
    OP_DUP   = 5'd4,  OP_ADD   = 5'd5,  OP_SUB   = 5'd6,  OP_MUL   = 5'd7,
    OP_DIV   = 5'd8,  OP_NEG   = 5'd9,  OP_INC   = 5'd10, OP_DEC   = 5'd11,
    OP_EQ    = 5'd12, OP_NE    = 5'd13, OP_LT    = 5'd14, OP_GT    = 5'd15,
    OP_LE    = 5'd16, OP_GE    = 5'd17, OP_NOT   = 5'd18, OP_LOAD  = 5'd19,
    OP_STORE = 5'd20, OP_JMP   = 5'd21, OP_JIF   = 5'd22, OP_JIT   = 5'd23,
    OP_JBACK = 5'd24, OP_RET   = 5'd25, OP_RETV  = 5'd26
  } op_e;

  typedef enum logic [2:0] {
    ERR_NONE  = 3'd0,
    ERR_DIVZ  = 3'd1,
    ERR_OVER  = 3'd2,
    ERR_UNDER = 3'd3,
    ERR_SLOT  = 3'd4
  } err_e;

  localparam int InWidth  = 88;
  localparam int ResWidth = 158;
  localparam int OutWidth = 160;

  // decoded request handed from front to back
  typedef struct packed {
    op_e         op;
    logic [63:0] value;
    logic [15:0] index;
    logic [1:0]  need;     // entries the op consumes
    logic        push;     // op grows the stack
    logic        slot_op;  // load or store
  } dec_t;

  // result, first field in the highest bits
  typedef struct packed {
    err_e        error;
    logic [63:0] ret_val;
    logic        has_return;
    logic        finished;
    logic        safepoint_request;
    logic [15:0] jump_target;
    logic        jump_taken;
    logic [6:0]  depth;
    logic [63:0] top_value;
  } res_t;

  typedef struct packed {
    logic clearing;
  } sts_t;

endpackage

/* hw/rtl/sbeu_front.sv */
// ----------------------------------------------------------------------------
// sbeu_front
// Accepts instruction requests and decodes them for the queue.
// ----------------------------------------------------------------------------
module sbeu_front (
  input  logic                       s_valid_i,
  output logic                       s_ready_o,
  input  logic [sbeu_pkg::InWidth-1:0] s_data_i,
  input  logic                       q_full_i,
  input  sbeu_pkg::sts_t             sts_i,
  output logic                       q_push_o,
  output sbeu_pkg::dec_t             q_data_o
);

  logic [4:0] mode;

  assign mode      = s_data_i[4:0];
  assign s_ready_o = !q_full_i && !sts_i.clearing;
  assign q_push_o  = s_valid_i && s_ready_o;

  always_comb begin
    q_data_o       = '0;
    q_data_o.value = s_data_i[68:5];
    q_data_o.index = s_data_i[84:69];
    // unknown modes behave as nop
    if (mode <= sbeu_pkg::OP_RETV) begin
      q_data_o.op = sbeu_pkg::op_e'(mode);
    end else begin
      q_data_o.op = sbeu_pkg::OP_NOP;
    end
    case (q_data_o.op)
      sbeu_pkg::OP_POP, sbeu_pkg::OP_DUP, sbeu_pkg::OP_NEG, sbeu_pkg::OP_INC,
      sbeu_pkg::OP_DEC, sbeu_pkg::OP_NOT, sbeu_pkg::OP_STORE, sbeu_pkg::OP_JIF,
      sbeu_pkg::OP_JIT, sbeu_pkg::OP_RETV: begin
        q_data_o.need = 2'd1;
      end
      sbeu_pkg::OP_ADD, sbeu_pkg::OP_SUB, sbeu_pkg::OP_MUL, sbeu_pkg::OP_DIV,
      sbeu_pkg::OP_EQ, sbeu_pkg::OP_NE, sbeu_pkg::OP_LT, sbeu_pkg::OP_GT,
      sbeu_pkg::OP_LE, sbeu_pkg::OP_GE: begin
        q_data_o.need = 2'd2;
      end
      default: begin
        q_data_o.need = 2'd0;
      end
    endcase
    q_data_o.push = (q_data_o.op == sbeu_pkg::OP_PUSHI) || (q_data_o.op == sbeu_pkg::OP_PUSHB) ||
                    (q_data_o.op == sbeu_pkg::OP_DUP) || (q_data_o.op == sbeu_pkg::OP_LOAD);
    q_data_o.slot_op = (q_data_o.op == sbeu_pkg::OP_LOAD) ||
                       (q_data_o.op == sbeu_pkg::OP_STORE);
  end

endmodule

/* hw/rtl/sbeu_queue.sv */
// ----------------------------------------------------------------------------
// sbeu_queue
// Two-entry request queue between decode and execute.
// ----------------------------------------------------------------------------
module sbeu_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  sbeu_pkg::dec_t data_i,
  output logic           full_o,
  output logic           valid_o,
  input  logic           pop_i,
  output sbeu_pkg::dec_t data_o
);

  sbeu_pkg::dec_t ent_q [2];
  logic           wptr_q, rptr_q;
  logic [1:0]     cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = ent_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wptr_q <= !wptr_q;
      end
      if (pop_i) begin
        rptr_q <= !rptr_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

/* hw/rtl/sbeu_back.sv */
// ----------------------------------------------------------------------------
// sbeu_back
// Execute sequencer: operand stack and local memories, shared 32x32
// multiplier, radix-2 divider and the result register.
// ----------------------------------------------------------------------------
module sbeu_back #(
  parameter int STACK_DEPTH = 64,
  parameter int LOCAL_SLOTS = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_valid_i,
  input  sbeu_pkg::dec_t                q_data_i,
  output logic                          q_pop_o,
  output sbeu_pkg::sts_t                sts_o,
  output logic                          m_valid_o,
  input  logic                          m_ready_i,
  output sbeu_pkg::res_t                m_data_o
);

  localparam int SA = $clog2(STACK_DEPTH);
  localparam int DW = $clog2(STACK_DEPTH + 1);
  localparam int LA = (LOCAL_SLOTS > 1) ? $clog2(LOCAL_SLOTS) : 1;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_RD1, S_RD2, S_MUL, S_DIV, S_ZERO, S_OUT
  } state_e;

  state_e         state_q;
  sbeu_pkg::dec_t ins_q;
  logic [DW-1:0]  depth_q;
  logic [63:0]    r_q;
  logic [LA-1:0]  clr_q;
  logic [1:0]     mcnt_q;
  logic [6:0]     dcnt_q;
  logic [63:0]    prod_q, acc_q;
  logic [63:0]    rem_q, quo_q, dvs_q;
  logic           neg_q;
  sbeu_pkg::res_t res_q, res_d, out_q;
  logic           out_vld_q;
  logic           out_load;

  // memories
  logic [63:0]    stk_mem [STACK_DEPTH];
  logic [63:0]    loc_mem [LOCAL_SLOTS];
  logic [63:0]    stk_rd_q, loc_rd_q;
  logic           stk_re, stk_we, loc_re, loc_we;
  logic [SA-1:0]  stk_raddr, stk_waddr;
  logic [63:0]    stk_wdata, loc_wdata;
  logic [LA-1:0]  loc_waddr;

  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    if (stk_re) begin
      stk_rd_q <= stk_mem[stk_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (loc_we) begin
      loc_mem[loc_waddr] <= loc_wdata;
    end
    if (loc_re) begin
      loc_rd_q <= loc_mem[q_data_i.index[LA-1:0]];
    end
  end

  logic [DW-1:0] dm1, dm2, dp1;
  logic [63:0]   rv, lv;
  assign dm1 = depth_q - DW'(1);
  assign dm2 = depth_q - DW'(2);
  assign dp1 = depth_q + DW'(1);
  assign rv  = r_q;
  assign lv  = stk_rd_q;

  assign q_pop_o        = (state_q == S_IDLE) && q_valid_i;
  assign sts_o.clearing = (state_q == S_CLEAR);
  assign m_valid_o      = out_vld_q;
  assign m_data_o       = out_q;
  assign stk_re         = q_pop_o || (state_q == S_RD1);
  assign stk_raddr      = (state_q == S_IDLE) ? dm1[SA-1:0] : dm2[SA-1:0];
  assign loc_re         = q_pop_o;
  assign out_load       = (state_q == S_OUT) && (!out_vld_q || m_ready_i);

  // error checks and the ops that complete without S_MUL or S_DIV, evaluated in S_RD2
  sbeu_pkg::err_e err;
  logic           ex_we, ex_jt, ex_sp;
  logic [DW-1:0]  ex_waddr, ex_depth;
  logic [63:0]    ex_wdata, ex_top, top_keep, top_pop;
  logic           lt_lr, lt_rl;

  assign lt_lr    = $signed(lv) < $signed(rv);
  assign lt_rl    = $signed(rv) < $signed(lv);
  assign top_keep = (depth_q != '0) ? rv : '0;
  assign top_pop  = (depth_q >= DW'(2)) ? lv : '0;

  always_comb begin
    if (ins_q.slot_op && (32'(ins_q.index) >= LOCAL_SLOTS)) begin
      err = sbeu_pkg::ERR_SLOT;
    end else if (depth_q < DW'(ins_q.need)) begin
      err = sbeu_pkg::ERR_UNDER;
    end else if (ins_q.push && (depth_q == DW'(STACK_DEPTH))) begin
      err = sbeu_pkg::ERR_OVER;
    end else if ((ins_q.op == sbeu_pkg::OP_DIV) && (rv == '0)) begin
      err = sbeu_pkg::ERR_DIVZ;
    end else begin
      err = sbeu_pkg::ERR_NONE;
    end
  end

  always_comb begin
    ex_we    = 1'b0;
    ex_waddr = dm2;
    ex_wdata = '0;
    ex_depth = depth_q;
    ex_top   = top_keep;
    ex_jt    = 1'b0;
    ex_sp    = 1'b0;
    case (ins_q.op)
      sbeu_pkg::OP_PUSHI, sbeu_pkg::OP_PUSHB, sbeu_pkg::OP_DUP, sbeu_pkg::OP_LOAD: begin
        ex_we    = 1'b1;
        ex_waddr = depth_q;
        ex_depth = dp1;
        case (ins_q.op)
          sbeu_pkg::OP_PUSHI: ex_wdata = ins_q.value;
          sbeu_pkg::OP_PUSHB: ex_wdata = {63'd0, ins_q.value != '0};
          sbeu_pkg::OP_DUP:   ex_wdata = rv;
          default:            ex_wdata = loc_rd_q;
        endcase
        ex_top = ex_wdata;
      end
      sbeu_pkg::OP_POP: begin
        ex_depth = dm1;
        ex_top   = top_pop;
      end
      sbeu_pkg::OP_ADD, sbeu_pkg::OP_SUB, sbeu_pkg::OP_EQ, sbeu_pkg::OP_NE,
      sbeu_pkg::OP_LT, sbeu_pkg::OP_GT, sbeu_pkg::OP_LE, sbeu_pkg::OP_GE: begin
        ex_we    = 1'b1;
        ex_depth = dm1;
        case (ins_q.op)
          sbeu_pkg::OP_ADD: ex_wdata = lv + rv;
          sbeu_pkg::OP_SUB: ex_wdata = lv - rv;
          sbeu_pkg::OP_EQ:  ex_wdata = {63'd0, lv == rv};
          sbeu_pkg::OP_NE:  ex_wdata = {63'd0, lv != rv};
          sbeu_pkg::OP_LT:  ex_wdata = {63'd0, lt_lr};
          sbeu_pkg::OP_GT:  ex_wdata = {63'd0, lt_rl};
          sbeu_pkg::OP_LE:  ex_wdata = {63'd0, !lt_rl};
          default:          ex_wdata = {63'd0, !lt_lr};
        endcase
        ex_top = ex_wdata;
      end
      sbeu_pkg::OP_NEG, sbeu_pkg::OP_INC, sbeu_pkg::OP_DEC, sbeu_pkg::OP_NOT: begin
        ex_we    = 1'b1;
        ex_waddr = dm1;
        case (ins_q.op)
          sbeu_pkg::OP_NEG: ex_wdata = '0 - rv;
          sbeu_pkg::OP_INC: ex_wdata = rv + 64'd1;
          sbeu_pkg::OP_DEC: ex_wdata = rv - 64'd1;
          default:          ex_wdata = {63'd0, rv == '0};
        endcase
        ex_top = ex_wdata;
      end
      sbeu_pkg::OP_JMP: begin
        ex_jt = 1'b1;
      end
      sbeu_pkg::OP_JIF, sbeu_pkg::OP_JIT: begin
        ex_depth = dm1;
        ex_top   = top_pop;
        ex_jt    = (ins_q.op == sbeu_pkg::OP_JIF) ? (rv == '0) : (rv != '0);
      end
      sbeu_pkg::OP_JBACK: begin
        ex_jt = 1'b1;
        ex_sp = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // multiplier: low 64 bits from three 32x32 partial products
  logic [31:0]  mul_a, mul_b;
  logic [63:0]  prod_d, mul_res;
  always_comb begin
    case (mcnt_q)
      2'd0:    begin mul_a = lv[31:0];  mul_b = rv[31:0];  end
      2'd1:    begin mul_a = lv[31:0];  mul_b = rv[63:32]; end
      default: begin mul_a = lv[63:32]; mul_b = rv[31:0];  end
    endcase
  end
  assign prod_d  = 64'(mul_a) * 64'(mul_b);
  assign mul_res = acc_q + {prod_q[31:0], 32'd0};

  // divider step on magnitudes
  logic [64:0] rem_sh, diff;
  logic [63:0] div_res;
  assign rem_sh  = {rem_q, quo_q[63]};
  assign diff    = rem_sh - {1'b0, dvs_q};
  assign div_res = neg_q ? ('0 - quo_q) : quo_q;

  // next result record
  always_comb begin
    res_d = res_q;
    case (state_q)
      S_RD2: begin
        res_d       = '0;
        res_d.depth = 7'(depth_q);
        res_d.error = err;
        if (err != sbeu_pkg::ERR_NONE) begin
          res_d.top_value = top_keep;
        end else if ((ins_q.op == sbeu_pkg::OP_RET) || (ins_q.op == sbeu_pkg::OP_RETV)) begin
          res_d.depth      = '0;
          res_d.finished   = 1'b1;
          res_d.has_return = (ins_q.op == sbeu_pkg::OP_RETV);
          res_d.ret_val    = (ins_q.op == sbeu_pkg::OP_RETV) ? rv : '0;
        end else if ((ins_q.op != sbeu_pkg::OP_MUL) && (ins_q.op != sbeu_pkg::OP_DIV)) begin
          res_d.depth             = 7'(ex_depth);
          res_d.top_value         = ex_top;
          res_d.jump_taken        = ex_jt;
          res_d.jump_target       = ex_jt ? ins_q.index : '0;
          res_d.safepoint_request = ex_sp;
        end
      end
      S_MUL: begin
        if (mcnt_q == 2'd3) begin
          res_d.depth     = 7'(dm1);
          res_d.top_value = mul_res;
        end
      end
      S_DIV: begin
        if (dcnt_q == 7'd64) begin
          res_d.depth     = 7'(dm1);
          res_d.top_value = div_res;
        end
      end
      default: begin
      end
    endcase
  end

  // memory write ports
  always_comb begin
    stk_we    = 1'b0;
    stk_waddr = ex_waddr[SA-1:0];
    stk_wdata = ex_wdata;
    loc_we    = 1'b0;
    loc_waddr = clr_q;
    loc_wdata = '0;
    case (state_q)
      S_RD2: begin
        stk_we = (err == sbeu_pkg::ERR_NONE) && ex_we;
        if ((err == sbeu_pkg::ERR_NONE) && (ins_q.op == sbeu_pkg::OP_STORE)) begin
          loc_we    = 1'b1;
          loc_waddr = ins_q.index[LA-1:0];
          loc_wdata = rv;
        end
      end
      S_MUL: begin
        stk_we    = (mcnt_q == 2'd3);
        stk_waddr = dm2[SA-1:0];
        stk_wdata = mul_res;
      end
      S_DIV: begin
        stk_we    = (dcnt_q == 7'd64);
        stk_waddr = dm2[SA-1:0];
        stk_wdata = div_res;
      end
      S_CLEAR, S_ZERO: begin
        loc_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      depth_q   <= '0;
      clr_q     <= '0;
      mcnt_q    <= '0;
      dcnt_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      res_q <= res_d;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (m_ready_i) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        S_CLEAR, S_ZERO: begin
          if (clr_q == LA'(LOCAL_SLOTS - 1)) begin
            clr_q   <= '0;
            state_q <= (state_q == S_CLEAR) ? S_IDLE : S_OUT;
          end else begin
            clr_q <= clr_q + LA'(1);
          end
        end
        S_IDLE: begin
          if (q_valid_i) begin
            ins_q   <= q_data_i;
            state_q <= S_RD1;
          end
        end
        S_RD1: begin
          r_q     <= stk_rd_q;
          state_q <= S_RD2;
        end
        S_RD2: begin
          if (err != sbeu_pkg::ERR_NONE) begin
            state_q <= S_OUT;
          end else if (ins_q.op == sbeu_pkg::OP_MUL) begin
            mcnt_q  <= '0;
            state_q <= S_MUL;
          end else if (ins_q.op == sbeu_pkg::OP_DIV) begin
            rem_q   <= '0;
            quo_q   <= lv[63] ? ('0 - lv) : lv;
            dvs_q   <= rv[63] ? ('0 - rv) : rv;
            neg_q   <= lv[63] ^ rv[63];
            dcnt_q  <= '0;
            state_q <= S_DIV;
          end else if ((ins_q.op == sbeu_pkg::OP_RET) || (ins_q.op == sbeu_pkg::OP_RETV)) begin
            depth_q <= '0;
            clr_q   <= '0;
            state_q <= S_ZERO;
          end else begin
            depth_q <= ex_depth;
            state_q <= S_OUT;
          end
        end
        S_MUL: begin
          mcnt_q <= mcnt_q + 2'd1;
          prod_q <= prod_d;
          case (mcnt_q)
            2'd1:    acc_q <= prod_q;
            2'd2:    acc_q <= mul_res;
            default: begin
            end
          endcase
          if (mcnt_q == 2'd3) begin
            depth_q <= dm1;
            state_q <= S_OUT;
          end
        end
        S_DIV: begin
          dcnt_q <= dcnt_q + 7'd1;
          if (dcnt_q == 7'd64) begin
            depth_q <= dm1;
            state_q <= S_OUT;
          end else begin
            rem_q <= diff[64] ? rem_sh[63:0] : diff[63:0];
            quo_q <= {quo_q[62:0], !diff[64]};
          end
        end
        S_OUT: begin
          if (out_load) begin
            out_q   <= res_q;
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* hw/rtl/stack_bytecode_execute_unit.sv */
// ----------------------------------------------------------------------------
// stack_bytecode_execute_unit
// Integer bytecode executor with operand stack and local slots.
// ----------------------------------------------------------------------------
//  channel   dir  bits  contents
//  s_axis    in   88    mode[4:0] value[68:5] index[84:69]
//  m_axis    out  160   top_value, depth, jump/safepoint, return, error
//
// Each instruction passes the execute states S_IDLE, S_RD1 and S_RD2, then S_OUT
// and the result register; mul adds the S_MUL steps (shared 32x32 multiplier, three
// partial products), div adds the S_DIV steps (one quotient bit per cycle).
// return with or without value then sweeps every local slot to zero (S_ZERO).
// After reset the locals are cleared while s_axis_tready is held low.
// A stalled result holds in the output register; the next request may proceed
// up to the result stage.
module stack_bytecode_execute_unit #(
  parameter int STACK_DEPTH = 64,
  parameter int LOCAL_SLOTS = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [sbeu_pkg::InWidth-1:0]  s_axis_tdata,   // mode, value, index
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // top_value, depth, jump_taken, jump_target, safepoint_request, finished,
  // has_return, ret_val, error
  output logic [sbeu_pkg::OutWidth-1:0] m_axis_tdata
);

  sbeu_pkg::sts_t sts;
  sbeu_pkg::dec_t dec, q_data;
  sbeu_pkg::res_t res;
  logic           push, full, q_valid, pop;

  sbeu_front u_front (
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .s_data_i  (s_axis_tdata),
    .q_full_i  (full),
    .sts_i     (sts),
    .q_push_o  (push),
    .q_data_o  (dec)
  );

  sbeu_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (dec),
    .full_o  (full),
    .valid_o (q_valid),
    .pop_i   (pop),
    .data_o  (q_data)
  );

  sbeu_back #(
    .STACK_DEPTH (STACK_DEPTH),
    .LOCAL_SLOTS (LOCAL_SLOTS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_data_i  (q_data),
    .q_pop_o   (pop),
    .sts_o     (sts),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_data_o  (res)
  );

  assign m_axis_tdata = {2'b00, res};

`ifndef SYNTHESIS
  a_clear_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.clearing |-> !s_axis_tready) else $error("request taken during clear");
  a_err_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (res.error != sbeu_pkg::ERR_NONE) |->
      !res.jump_taken && !res.finished && !res.has_return)
    else $error("error result carries side effects");
  a_ret_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res.finished |-> (res.depth == '0) && (res.top_value == '0))
    else $error("return left stack nonempty");
  a_pop_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> q_valid) else $error("pop from empty queue");
`endif

endmodule
